/* rtl/core/gtcs_pkg.sv */
// gtcs_pkg: shared constants, register and reaction codes, and the request
// and response structs between the two-compartment stochastic step core
// and its divider and histogram store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtcs_pkg;

	localparam int COUNT_BITS = 16;
	localparam int HIST_BINS  = 256;
	localparam int HB_W       = $clog2(HIST_BINS);
	localparam int DIV_W      = 48;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic [31:0] LN2_Q32  = 32'hB17217F7;
	localparam logic [29:0] LOG_BIAS = 30'(32) << 24;

	typedef enum logic [2:0] {
		REG_BASAL   = 3'd0,
		REG_INDUCED = 3'd1,
		REG_HALF    = 3'd2,
		REG_DECAY   = 3'd3,
		REG_DIFF    = 3'd4,
		REG_VOLUME  = 3'd5,
		REG_END     = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		RX_HOP12  = 3'd0,
		RX_HOP21  = 3'd1,
		RX_DECAY1 = 3'd2,
		RX_DECAY2 = 3'd3,
		RX_PROD1  = 3'd4,
		RX_PROD2  = 3'd5,
		RX_NONE   = 3'd6
	} rxn_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic            we;
		logic [HB_W-1:0] waddr;
		logic [47:0]     wdata;
		logic [HB_W-1:0] raddr;
	} hist_req_t;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/gtcs_div.sv */
// gtcs_div: restoring divider, one quotient bit per cycle.
// Depends on gtcs_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module gtcs_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gtcs_pkg::div_req_t req,
	output gtcs_pkg::div_rsp_t      rsp
);

	logic [gtcs_pkg::DIV_W-1:0]     rem_q, quo_q, dsr_q;
	logic [gtcs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q, done_q;
	logic [gtcs_pkg::DIV_W:0]       trial, diff;
	logic                           fits;

	assign trial = {rem_q, quo_q[gtcs_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gtcs_pkg::DIV_CNT_W'(gtcs_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[gtcs_pkg::DIV_W-1:0] : trial[gtcs_pkg::DIV_W-1:0];
			quo_q <= {quo_q[gtcs_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/core/gtcs_hist.sv */
// gtcs_hist: dwell-time histogram store, one write and one registered read
// per cycle; per-bin valid flags make a never-written bin read as zero.
// Depends on gtcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtcs_hist (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gtcs_pkg::hist_req_t req,
	output logic [47:0]              rd_data
);

	logic [47:0]                    mem_q [gtcs_pkg::HIST_BINS];
	logic [gtcs_pkg::HIST_BINS-1:0] valid_q;
	logic [47:0]                    rd_q;
	logic                           rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[req.raddr];
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[req.raddr];
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	assign rd_data = rd_vld_q ? rd_q : 48'd0;

endmodule

`default_nettype wire

/* rtl/core/gillespie_two_compartment_step.sv */
// Two-compartment direct-method stochastic step: a request in step mode
// spends most of its time in five waits on the shared divider when all five
// divisions run (two per Hill term, one for the waiting time) and in 24
// squaring passes of the shared 32x32 multiplier for the logarithm; the time
// taken varies with the leading zeros of rand_time and the reaction picked,
// and a zero Hill denominator or a zero propensity sum skips that division.
// A step after end_time goes from acceptance straight to the output state,
// a histogram read through ST_RD1 and ST_RD2 first. One request is in
// flight at a time; the next can be accepted while a result waits.
// Depends on gtcs_pkg, gtcs_div and gtcs_hist.
`timescale 1ns / 1ps
`default_nettype none

module gillespie_two_compartment_step (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [71:0]  s_tdata,  // rand_time, rand_pick, bin_index
	input  wire logic [0:0]   s_tuser,  // mode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [167:0]      m_tdata   // reaction, count_one, count_two, wait_time,
	                                    // elapsed, finished, bin_value, zero pad
);

	localparam int CB = gtcs_pkg::COUNT_BITS;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD1, ST_RD2,
		ST_H_DEN, ST_H_CDIV, ST_H_CWAIT, ST_H_SQ1, ST_H_SQ2, ST_H_SQ3, ST_H_SQ4,
		ST_H_HWAIT, ST_H_K1, ST_H_K2, ST_H_K3, ST_H_K4,
		ST_P_MUL, ST_P_ACC, ST_L_NORM, ST_L_SQ, ST_L_FIX, ST_L_LN,
		ST_T_DIV, ST_T_WAIT, ST_G_HI, ST_G_LO, ST_G_ADD, ST_HIST,
		ST_PICK, ST_UPD, ST_OUT
	} state_t;

	logic [23:0] basal_q, induced_q, half_q, decay_q, diff_q;
	logic [7:0]  volume_q;
	logic [31:0] end_q;

	state_t            st_q;
	logic              side_q;
	logic [31:0]       u2_q;
	logic [7:0]        bidx_q;
	logic [CB-1:0]     n1_q, n2_q;
	logic [47:0]       sim_q;
	logic [63:0]       prod_q;
	logic [31:0]       c_q, pa_q, m_q, tau_q;
	logic [15:0]       h_q;
	logic [47:0]       p_q [6];
	logic [47:0]       sum_q, tgt_q, acc_q, binv_q;
	logic [2:0]        idx_q;
	logic [4:0]        e_q, it_q;
	logic [23:0]       frac_q;
	gtcs_pkg::rxn_t    rxn_q;
	logic              m_tvalid_q;
	logic [167:0]      m_tdata_q;

	logic [31:0]       mul_a, mul_b;
	logic              mul_en;
	logic [CB-1:0]     n_sel;
	logic [47:0]       limit;
	logic [CB:0]       bin_sum;
	logic              bin_ok;
	logic [29:0]       nl2;
	logic [31:0]       c4;
	logic [32:0]       sq;
	logic [47:0]       hp, acc_nx, hist_rd;
	logic [48:0]       sim_sum, hist_sum;
	logic [31:0]       u1_in;

	gtcs_pkg::div_req_t  div_req;
	gtcs_pkg::div_rsp_t  div_rsp;
	gtcs_pkg::hist_req_t hist_req;

	gtcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	gtcs_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hist_req),
		.rd_data (hist_rd)
	);

	function automatic logic [CB-1:0] inc_cnt(input logic [CB-1:0] n);
		return (&n) ? n : n + 1'b1;
	endfunction

	function automatic logic [CB-1:0] dec_cnt(input logic [CB-1:0] n);
		return (n == '0) ? n : n - 1'b1;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign n_sel    = side_q ? n2_q : n1_q;
	assign limit    = {end_q, 16'd0};
	assign bin_sum  = {1'b0, n1_q} + {1'b0, n2_q};
	assign bin_ok   = 32'(bin_sum) < 32'(gtcs_pkg::HIST_BINS);
	assign nl2      = gtcs_pkg::LOG_BIAS - {1'b0, e_q, frac_q};
	assign c4       = gtcs_pkg::sat32(prod_q >> 16);
	assign sq       = prod_q[63:31];
	assign hp       = 48'(pa_q) + prod_q[63:16];
	assign acc_nx   = acc_q + p_q[idx_q];
	assign sim_sum  = {1'b0, sim_q} + 49'(tau_q);
	assign hist_sum = {1'b0, hist_rd} + 49'(tau_q);
	assign u1_in    = (s_tdata[31:0] == 32'd0) ? 32'd1 : s_tdata[31:0];

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (st_q)
			ST_H_DEN: begin
				mul_a = 32'(volume_q);
				mul_b = 32'(half_q);
			end
			ST_H_SQ1, ST_H_SQ3: begin
				mul_a = c_q;
				mul_b = c_q;
			end
			ST_H_K1: begin
				mul_a = 32'(volume_q);
				mul_b = 32'(basal_q);
			end
			ST_H_K2: begin
				mul_a = 32'(volume_q);
				mul_b = 32'(induced_q);
			end
			ST_H_K3: begin
				mul_a = prod_q[31:0];
				mul_b = 32'(h_q);
			end
			ST_P_MUL: begin
				mul_a = idx_q[1] ? 32'(decay_q) : 32'(diff_q);
				mul_b = idx_q[0] ? 32'(n2_q) : 32'(n1_q);
			end
			ST_L_SQ: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_L_LN: begin
				mul_a = 32'(nl2);
				mul_b = gtcs_pkg::LN2_Q32;
			end
			ST_G_HI: begin
				mul_a = 32'(sum_q[47:32]);
				mul_b = u2_q;
			end
			ST_G_LO: begin
				mul_a = sum_q[31:0];
				mul_b = u2_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (st_q)
			ST_H_CDIV: begin
				div_req.start    = (prod_q[31:0] != 32'd0);
				div_req.dividend = gtcs_pkg::DIV_W'({n_sel, 32'd0});
				div_req.divisor  = gtcs_pkg::DIV_W'(prod_q[31:0]);
			end
			ST_H_SQ4: begin
				div_req.start    = 1'b1;
				div_req.dividend = {c4, 16'd0};
				div_req.divisor  = 48'(c4) + 48'h1_0000;
			end
			ST_T_DIV: begin
				div_req.start    = (sum_q != 48'd0);
				div_req.dividend = gtcs_pkg::DIV_W'({prod_q[61:40], 16'd0});
				div_req.divisor  = sum_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		hist_req.raddr = (st_q == ST_RD1) ? gtcs_pkg::HB_W'(bidx_q)
		                                  : gtcs_pkg::HB_W'(bin_sum);
		hist_req.waddr = gtcs_pkg::HB_W'(bin_sum);
		hist_req.wdata = hist_sum[48] ? 48'hFFFF_FFFF_FFFF : hist_sum[47:0];
		hist_req.we    = (st_q == ST_HIST) && bin_ok;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basal_q   <= 24'd13107;
			induced_q <= 24'd114688;
			half_q    <= 24'd65536;
			decay_q   <= 24'd65536;
			diff_q    <= 24'd655;
			volume_q  <= 8'd8;
			end_q     <= 32'd10000;
		end else if (cfg_valid && cfg_ready) begin
			case (gtcs_pkg::cfg_reg_t'(cfg_index))
				gtcs_pkg::REG_BASAL:   basal_q   <= cfg_data[23:0];
				gtcs_pkg::REG_INDUCED: induced_q <= cfg_data[23:0];
				gtcs_pkg::REG_HALF:    half_q    <= cfg_data[23:0];
				gtcs_pkg::REG_DECAY:   decay_q   <= cfg_data[23:0];
				gtcs_pkg::REG_DIFF:    diff_q    <= cfg_data[23:0];
				gtcs_pkg::REG_VOLUME:  volume_q  <= cfg_data[7:0];
				gtcs_pkg::REG_END:     end_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			side_q     <= 1'b0;
			u2_q       <= '0;
			bidx_q     <= '0;
			n1_q       <= '0;
			n2_q       <= '0;
			sim_q      <= '0;
			prod_q     <= '0;
			c_q        <= '0;
			pa_q       <= '0;
			m_q        <= '0;
			tau_q      <= '0;
			h_q        <= '0;
			for (int i = 0; i < 6; i++) p_q[i] <= '0;
			sum_q      <= '0;
			tgt_q      <= '0;
			acc_q      <= '0;
			binv_q     <= '0;
			idx_q      <= '0;
			e_q        <= '0;
			it_q       <= '0;
			frac_q     <= '0;
			rxn_q      <= gtcs_pkg::RX_NONE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (mul_en) begin
				prod_q <= mul_a * mul_b;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						u2_q   <= s_tdata[63:32];
						bidx_q <= s_tdata[71:64];
						m_q    <= u1_in;
						e_q    <= 5'd31;
						frac_q <= '0;
						it_q   <= '0;
						idx_q  <= '0;
						side_q <= 1'b0;
						sum_q  <= '0;
						acc_q  <= '0;
						tau_q  <= '0;
						binv_q <= '0;
						rxn_q  <= gtcs_pkg::RX_NONE;
						if (s_tuser[0]) begin
							st_q <= ST_RD1;
						end else if (sim_q >= limit) begin
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_H_DEN;
						end
					end
				end
				ST_RD1: st_q <= ST_RD2;
				ST_RD2: begin
					binv_q <= (32'(bidx_q) < 32'(gtcs_pkg::HIST_BINS)) ? hist_rd : 48'd0;
					st_q   <= ST_OUT;
				end
				ST_H_DEN: st_q <= ST_H_CDIV;
				ST_H_CDIV: begin
					if (prod_q[31:0] == 32'd0) begin
						c_q  <= (n_sel == '0) ? 32'd0 : 32'hFFFF_FFFF;
						st_q <= ST_H_SQ1;
					end else begin
						st_q <= ST_H_CWAIT;
					end
				end
				ST_H_CWAIT: begin
					if (div_rsp.done) begin
						c_q  <= gtcs_pkg::sat32(64'(div_rsp.quotient));
						st_q <= ST_H_SQ1;
					end
				end
				ST_H_SQ1: st_q <= ST_H_SQ2;
				ST_H_SQ2: begin
					c_q  <= gtcs_pkg::sat32(prod_q >> 16);
					st_q <= ST_H_SQ3;
				end
				ST_H_SQ3: st_q <= ST_H_SQ4;
				ST_H_SQ4: st_q <= ST_H_HWAIT;
				ST_H_HWAIT: begin
					if (div_rsp.done) begin
						h_q  <= div_rsp.quotient[15:0];
						st_q <= ST_H_K1;
					end
				end
				ST_H_K1: st_q <= ST_H_K2;
				ST_H_K2: begin
					pa_q <= prod_q[31:0];
					st_q <= ST_H_K3;
				end
				ST_H_K3: st_q <= ST_H_K4;
				ST_H_K4: begin
					p_q[side_q ? 5 : 4] <= hp;
					sum_q <= sum_q + hp;
					if (side_q) begin
						st_q <= ST_P_MUL;
					end else begin
						side_q <= 1'b1;
						st_q   <= ST_H_DEN;
					end
				end
				ST_P_MUL: st_q <= ST_P_ACC;
				ST_P_ACC: begin
					p_q[idx_q] <= prod_q[47:0];
					sum_q      <= sum_q + prod_q[47:0];
					if (idx_q == 3'd3) begin
						idx_q <= '0;
						st_q  <= ST_L_NORM;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= ST_P_MUL;
					end
				end
				ST_L_NORM: begin
					if (m_q[31]) begin
						st_q <= ST_L_SQ;
					end else begin
						m_q <= {m_q[30:0], 1'b0};
						e_q <= e_q - 1'b1;
					end
				end
				ST_L_SQ: st_q <= ST_L_FIX;
				ST_L_FIX: begin
					frac_q <= {frac_q[22:0], sq[32]};
					m_q    <= sq[32] ? sq[32:1] : sq[31:0];
					it_q   <= it_q + 1'b1;
					st_q   <= (it_q == 5'd23) ? ST_L_LN : ST_L_SQ;
				end
				ST_L_LN: st_q <= ST_T_DIV;
				ST_T_DIV: begin
					if (sum_q == 48'd0) begin
						tau_q <= 32'hFFFF_FFFF;
						st_q  <= ST_G_HI;
					end else begin
						st_q <= ST_T_WAIT;
					end
				end
				ST_T_WAIT: begin
					if (div_rsp.done) begin
						tau_q <= gtcs_pkg::sat32(64'(div_rsp.quotient));
						st_q  <= ST_G_HI;
					end
				end
				ST_G_HI: st_q <= ST_G_LO;
				ST_G_LO: begin
					tgt_q <= prod_q[47:0];
					st_q  <= ST_G_ADD;
				end
				ST_G_ADD: begin
					tgt_q <= tgt_q + 48'(prod_q[63:32]);
					sim_q <= sim_sum[48] ? 48'hFFFF_FFFF_FFFF : sim_sum[47:0];
					st_q  <= ST_HIST;
				end
				ST_HIST: st_q <= (sum_q == 48'd0) ? ST_OUT : ST_PICK;
				ST_PICK: begin
					if ((tgt_q < acc_nx) || (idx_q == 3'd5)) begin
						rxn_q <= gtcs_pkg::rxn_t'(idx_q);
						st_q  <= ST_UPD;
					end else begin
						acc_q <= acc_nx;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_UPD: begin
					case (rxn_q)
						gtcs_pkg::RX_HOP12: begin
							n1_q <= dec_cnt(n1_q);
							n2_q <= inc_cnt(n2_q);
						end
						gtcs_pkg::RX_HOP21: begin
							n2_q <= dec_cnt(n2_q);
							n1_q <= inc_cnt(n1_q);
						end
						gtcs_pkg::RX_DECAY1: n1_q <= dec_cnt(n1_q);
						gtcs_pkg::RX_DECAY2: n2_q <= dec_cnt(n2_q);
						gtcs_pkg::RX_PROD1:  n1_q <= inc_cnt(n1_q);
						gtcs_pkg::RX_PROD2:  n2_q <= inc_cnt(n2_q);
						default: ;
					endcase
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold while the previous result still waits
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {4'd0, binv_q, (sim_q >= limit), sim_q, tau_q,
						               16'(n2_q), 16'(n1_q), rxn_q};
						m_tvalid_q <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_counts_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_UPD) |=> ($stable(n1_q) && $stable(n2_q)))
		else $error("molecule counts changed outside the update state");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(st_q) == ST_OUT))
		else $error("result raised outside the output state");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		sim_q >= $past(sim_q))
		else $error("simulated time went backward");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (st_q == ST_H_CWAIT || st_q == ST_H_HWAIT || st_q == ST_T_WAIT))
		else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire
